/* rtl/deq_pkg.sv */
package deq_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int FUNC_W  = 3;

    localparam logic [WORD_W-1:0]  EMPTY_REPLY = '1;
    localparam logic [COUNT_W-1:0] FULL_COUNT  = COUNT_W'(DEPTH);
    localparam logic [ADDR_W-1:0]  LAST_SLOT   = ADDR_W'(DEPTH - 1);

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_SIZE       = 3'd4,
        FN_EMPTY      = 3'd5,
        FN_FRONT      = 3'd6,
        FN_BACK       = 3'd7
    } deq_func_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } deq_state_t;

    typedef struct packed {
        logic take;
        logic start_read;
        logic load_mem;
    } deq_ctl_t;

    typedef struct packed {
        logic empty;
        logic out_free;
    } deq_sts_t;

    // (base + offset) modulo DEPTH, for base < DEPTH and offset <= DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(
        input logic [ADDR_W-1:0]  base,
        input logic [COUNT_W-1:0] offset
    );
        logic [COUNT_W:0] sum;
        begin
            sum = {{(COUNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, offset};
            if (sum >= (COUNT_W + 1)'(DEPTH))
            begin
                sum = sum - (COUNT_W + 1)'(DEPTH);
            end
            return sum[ADDR_W-1:0];
        end
    endfunction

endpackage

/* rtl/deq_cmd_if.sv */
interface deq_cmd_if
    import deq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [WORD_W-1:0]   value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

/* rtl/deq_rsp_if.sv */
interface deq_rsp_if
    import deq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                printed;
    logic [WORD_W-1:0]   result;
    logic                dropped;

    modport source (output valid, printed, result, dropped, input ready);
    modport sink   (input valid, printed, result, dropped, output ready);
endinterface

/* rtl/double_ended_queue_engine.sv */
// channel  dir  payload                          handshake
// cmd      in   func[2:0], value[31:0]           valid / ready
// rsp      out  printed, result[31:0], dropped   valid / ready
//
// Push, size and empty requests, and any request on an empty queue, reply in the
// cycle after acceptance; pops and peeks on a non-empty queue pass the registered
// read of the ring store, then the reply register, and hold cmd.ready low for the
// read cycle. One request is in flight at a time; a new request may enter in the
// cycle the previous reply is taken. A stalled reply holds cmd.ready low.
// Reset clears head, count and the reply valid; the store needs no clearing.
module double_ended_queue_engine
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    deq_cmd_if.sink   cmd,
    deq_rsp_if.source rsp
);

    deq_ctl_t ctl;
    deq_sts_t sts;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_func  (cmd.func),
        .sts       (sts),
        .cmd_ready (cmd.ready),
        .ctl       (ctl)
    );

    deq_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .func        (cmd.func),
        .value       (cmd.value),
        .rsp_ready   (rsp.ready),
        .sts         (sts),
        .rsp_valid   (rsp.valid),
        .rsp_printed (rsp.printed),
        .rsp_result  (rsp.result),
        .rsp_dropped (rsp.dropped)
    );

endmodule

/* rtl/deq_ctrl.sv */
module deq_ctrl
    import deq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic [FUNC_W-1:0] cmd_func,
    input  deq_sts_t          sts,
    output logic              cmd_ready,
    output deq_ctl_t          ctl
);

    deq_state_t state_reg;
    deq_state_t state_next;
    logic       needs_read;

    always_comb
    begin
        unique case (cmd_func) inside
            FN_POP_FRONT, FN_POP_BACK, FN_FRONT, FN_BACK: needs_read = !sts.empty;
            default:                                      needs_read = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd_ready      = 1'b0;
        ctl.take       = 1'b0;
        ctl.start_read = 1'b0;
        ctl.load_mem   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready      = sts.out_free;
                ctl.take       = sts.out_free && cmd_valid;
                ctl.start_read = sts.out_free && cmd_valid && needs_read;
            end
            ST_READ:
            begin
                ctl.load_mem = 1'b1;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start_read)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/deq_dpath.sv */
module deq_dpath
    import deq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  deq_ctl_t          ctl,
    input  logic [FUNC_W-1:0] func,
    input  logic [WORD_W-1:0] value,
    input  logic              rsp_ready,
    output deq_sts_t          sts,
    output logic              rsp_valid,
    output logic              rsp_printed,
    output logic [WORD_W-1:0] rsp_result,
    output logic              rsp_dropped
);

    logic [WORD_W-1:0]  mem [DEPTH];
    logic [WORD_W-1:0]  rd_data_reg;

    logic [ADDR_W-1:0]  head_reg;
    logic [ADDR_W-1:0]  head_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               printed_reg;
    logic               printed_next;
    logic [WORD_W-1:0]  result_reg;
    logic [WORD_W-1:0]  result_next;
    logic               dropped_reg;
    logic               dropped_next;

    logic               empty;
    logic               full;
    logic [ADDR_W-1:0]  head_dec;
    logic [ADDR_W-1:0]  head_inc;
    logic [ADDR_W-1:0]  tail_slot;
    logic [ADDR_W-1:0]  back_slot;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic               load_direct;
    logic               d_printed;
    logic [WORD_W-1:0]  d_result;
    logic               d_dropped;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == FULL_COUNT);
    assign head_dec  = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
    assign head_inc  = ring_add(head_reg, COUNT_W'(1));
    assign tail_slot = ring_add(head_reg, count_reg);
    assign back_slot = ring_add(head_reg, count_reg - 1'b1);

    assign sts.empty    = empty;
    assign sts.out_free = !out_valid_reg || rsp_ready;

    assign load_direct = ctl.take && !ctl.start_read;

    // decode the request: pointer moves, store access, direct reply
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_slot;
        rd_addr    = head_reg;
        d_printed  = 1'b1;
        d_result   = '0;
        d_dropped  = 1'b0;
        unique case (func) inside
            FN_PUSH_FRONT:
            begin
                d_printed = 1'b0;
                d_dropped = full;
                wr_addr   = head_dec;
                if (ctl.take && !full)
                begin
                    wr_en      = 1'b1;
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            FN_PUSH_BACK:
            begin
                d_printed = 1'b0;
                d_dropped = full;
                if (ctl.take && !full)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            FN_POP_FRONT, FN_FRONT:
            begin
                d_result = EMPTY_REPLY;
                if (ctl.start_read && func == FN_POP_FRONT)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            FN_POP_BACK, FN_BACK:
            begin
                d_result = EMPTY_REPLY;
                rd_addr  = back_slot;
                if (ctl.start_read && func == FN_POP_BACK)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            FN_SIZE:
            begin
                d_result = {{(WORD_W - COUNT_W){1'b0}}, count_reg};
            end
            default:
            begin
                d_result = {{(WORD_W - 1){1'b0}}, empty};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (ctl.start_read)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        printed_next   = printed_reg;
        result_next    = result_reg;
        dropped_next   = dropped_reg;
        if (ctl.load_mem)
        begin
            out_valid_next = 1'b1;
            printed_next   = 1'b1;
            result_next    = rd_data_reg;
            dropped_next   = 1'b0;
        end
        else if (load_direct)
        begin
            out_valid_next = 1'b1;
            printed_next   = d_printed;
            result_next    = d_result;
            dropped_next   = d_dropped;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        printed_reg <= printed_next;
        result_reg  <= result_next;
        dropped_reg <= dropped_next;
    end

    assign rsp_valid   = out_valid_reg;
    assign rsp_printed = printed_reg;
    assign rsp_result  = result_reg;
    assign rsp_dropped = dropped_reg;

endmodule

/* verif/double_ended_queue_engine_checker.sv */
`timescale 1ns / 1ps

module double_ended_queue_engine_checker
    import deq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    deq_cmd_if   cmd,
    deq_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic              printed;
        logic [WORD_W-1:0] result;
        logic              dropped;
    } deq_reply_t;

    deq_reply_t         awaited_replies[$];
    logic [WORD_W-1:0]  ring_words [DEPTH];
    logic [ADDR_W-1:0]  front_slot;
    logic [COUNT_W-1:0] held;

    function automatic logic [ADDR_W-1:0] slot_after(int offset);
        return ADDR_W'((int'(front_slot) + offset) % DEPTH);
    endfunction

    function automatic deq_reply_t deque_apply(deq_func_t fn, logic [WORD_W-1:0] word);
        deq_reply_t reply;
        logic [ADDR_W-1:0] tail;
        reply = '{printed: 1'b1, result: '0, dropped: 1'b0};
        case (fn)
            FN_PUSH_FRONT, FN_PUSH_BACK:
            begin
                reply.printed = 1'b0;
                if (held == FULL_COUNT)
                begin
                    reply.dropped = 1'b1;
                end
                else if (fn == FN_PUSH_FRONT)
                begin
                    front_slot = slot_after(DEPTH - 1);
                    ring_words[front_slot] = word;
                    held = held + 1'b1;
                end
                else
                begin
                    ring_words[slot_after(int'(held))] = word;
                    held = held + 1'b1;
                end
            end
            FN_POP_FRONT, FN_FRONT:
            begin
                if (held == '0)
                begin
                    reply.result = EMPTY_REPLY;
                end
                else
                begin
                    reply.result = ring_words[front_slot];
                    if (fn == FN_POP_FRONT)
                    begin
                        front_slot = slot_after(1);
                        held = held - 1'b1;
                    end
                end
            end
            FN_POP_BACK, FN_BACK:
            begin
                if (held == '0)
                begin
                    reply.result = EMPTY_REPLY;
                end
                else
                begin
                    tail = slot_after(int'(held) - 1);
                    reply.result = ring_words[tail];
                    if (fn == FN_POP_BACK)
                    begin
                        held = held - 1'b1;
                    end
                end
            end
            FN_SIZE:
            begin
                reply.result = WORD_W'(held);
            end
            default:
            begin
                reply.result = (held == '0) ? WORD_W'(1) : '0;
            end
        endcase
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deq_reply_t want;
        deq_reply_t got;
        if (!rst_n)
        begin
            awaited_replies.delete();
            front_slot = '0;
            held       = '0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{printed: rsp.printed, result: rsp.result, dropped: rsp.dropped};
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply printed=%0b result=%0d dropped=%0b",
                             $time, got.printed, $signed(got.result), got.dropped);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited_replies[0];
                    awaited_replies.delete(0);
                    if (got.printed !== want.printed || got.result !== want.result
                        || got.dropped !== want.dropped)
                    begin
                        $display("%0t: reply mismatch expected printed=%0b result=%0d dropped=%0b",
                                 $time, want.printed, $signed(want.result), want.dropped);
                        $display("%0t:                actual printed=%0b result=%0d dropped=%0b",
                                 $time, got.printed, $signed(got.result), got.dropped);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                awaited_replies = {awaited_replies,
                                   deque_apply(deq_func_t'(cmd.func), cmd.value)};
            end
            pending <= awaited_replies.size();
        end
    end

endmodule

/* verif/double_ended_queue_engine_test.sv */
`timescale 1ns / 1ps

module double_ended_queue_engine_test;
    import deq_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic clk;
    logic rst_n;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   cycle_count    = 0;
    int   fail_count;
    int   pending;

    deq_cmd_if cmd_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue_engine DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    double_ended_queue_engine_checker deque_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("double_ended_queue_engine_test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(deq_func_t fn, logic [WORD_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func  <= fn;
        cmd_ch.value <= word;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // push_pct and pop_pct steer the fill level; the rest are size, empty and peeks
    task automatic random_requests(int count, int push_pct, int pop_pct);
        int pick;
        deq_func_t fn;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < push_pct)
            begin
                fn = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
            end
            else if (pick < push_pct + pop_pct)
            begin
                fn = $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
            end
            else
            begin
                fn = deq_func_t'($urandom_range(int'(FN_SIZE), int'(FN_BACK)));
            end
            send_request(fn, $urandom);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func  <= FN_SIZE;
        cmd_ch.value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(FN_EMPTY,      '0);
        send_request(FN_POP_FRONT,  '0);
        send_request(FN_POP_BACK,   '0);
        send_request(FN_FRONT,      '0);
        send_request(FN_BACK,       '0);
        send_request(FN_PUSH_FRONT, 32'h8000_0000);
        send_request(FN_PUSH_BACK,  32'h7fff_ffff);
        send_request(FN_PUSH_FRONT, 32'hffff_ffff);
        send_request(FN_PUSH_BACK,  32'h0000_0000);
        send_request(FN_SIZE,       32'hffff_ffff);
        send_request(FN_EMPTY,      32'hffff_ffff);
        send_request(FN_FRONT,      '0);
        send_request(FN_BACK,       '0);
        send_request(FN_POP_FRONT,  '0);
        send_request(FN_POP_BACK,   '0);
        send_request(FN_POP_FRONT,  '0);
        send_request(FN_POP_BACK,   '0);
        send_request(FN_POP_BACK,   '0);
        send_request(FN_SIZE,       '0);
        send_request(FN_PUSH_BACK,  32'h5555_aaaa);
        send_request(FN_POP_FRONT,  '0);
        send_request(FN_EMPTY,      '0);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_requests(40, 34, 33);

        // fill with pushes; with the run below this aims past the top so that pushes are refused
        send_idle_pct  = 86;
        recv_stall_pct = 0;
        random_requests(525, 99, 0);

        send_idle_pct  = 0;
        recv_stall_pct = 86;
        random_requests(525, 99, 0);

        send_idle_pct  = 16;
        recv_stall_pct = 16;
        random_requests(60, 30, 60);

        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("double_ended_queue_engine_test passed");
        end
        else
        begin
            $display("double_ended_queue_engine_test failed");
        end
        $finish;
    end

endmodule
